@@ rtl/gdod_pkg.sv @@
`timescale 1ns / 1ps

package gdod_pkg;

    localparam int YEAR_MAX_DEF = 9999;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 23;
    localparam int DIFF_W  = 23;
    localparam int STAT_W  = 2;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_PAD_W   = OUT_TDATA_W - (YEAR_W + MONTH_W + DAY_W + DIFF_W);
    localparam int IN_PAD_W    = IN_TDATA_W - (2 * (YEAR_W + MONTH_W + DAY_W) + OFF_W);

    // working widths sized for the widest year range
    localparam int YW     = 17;
    localparam int Q_W    = 11;
    localparam int DN_W   = 26;
    localparam int SN_W   = 27;
    localparam int CUM_W  = 9;
    localparam int MULB_W = 18;
    localparam int PROD_W = DN_W + MULB_W;

    localparam logic [MULB_W-1:0] DIV100_K = MULB_W'(167773);
    localparam int                DIV100_SH = 24;
    localparam logic [MULB_W-1:0] EST_K = MULB_W'(45934);
    localparam int                EST_SH = 24;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_DATE = 2'd1,
        STAT_RANGE    = 2'd2
    } t_status;

    typedef enum logic {
        MUL_DIV100,
        MUL_EST
    } t_mul_sel;

    typedef enum logic [1:0] {
        YSRC_A,
        YSRC_B,
        YSRC_CAND
    } t_ysrc;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_DATE_A,
        ACC_DIFF,
        ACC_SUB_YS,
        ACC_MONTH
    } t_acc_op;

    typedef enum logic [1:0] {
        YR_HOLD,
        YR_EST,
        YR_INC,
        YR_DEC
    } t_yr_op;

    typedef enum logic [1:0] {
        OUT_DATE,
        OUT_DIFF,
        OUT_BAD,
        OUT_RANGE
    } t_out_sel;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        t_mul_sel mul_sel;
        t_ysrc    ysrc;
        logic     ys_en;
        t_acc_op  acc_op;
        t_yr_op   yr_op;
        logic     mon_init;
        logic     out_load;
        t_out_sel out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic a_bad;
        logic b_bad;
        logic range_err;
        logic ys_gt;
        logic rem_ge;
        logic walk_done;
    } t_dp_sts;

    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    len = DAY_W'(30);
            4'd2:                                       len = leap ? DAY_W'(29) : DAY_W'(28);
            default:                                    len = '0;
        endcase
        return len;
    endfunction

    function automatic logic [CUM_W-1:0] cum_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
        logic [CUM_W-1:0] base;
        case (m)
            4'd2:    base = CUM_W'(31);
            4'd3:    base = CUM_W'(59);
            4'd4:    base = CUM_W'(90);
            4'd5:    base = CUM_W'(120);
            4'd6:    base = CUM_W'(151);
            4'd7:    base = CUM_W'(181);
            4'd8:    base = CUM_W'(212);
            4'd9:    base = CUM_W'(243);
            4'd10:   base = CUM_W'(273);
            4'd11:   base = CUM_W'(304);
            4'd12:   base = CUM_W'(334);
            default: base = '0;
        endcase
        return base + CUM_W'(leap && (m > 4'd2));
    endfunction

endpackage

@@ rtl/gdod_ctrl.sv @@
`timescale 1ns / 1ps

module gdod_ctrl
    import gdod_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_valid,
    output logic    o_s_ready,
    output logic    o_m_valid,
    input  logic    i_m_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_A_MUL,
        ST_A_YS,
        ST_A_DN,
        ST_B_MUL,
        ST_B_YS,
        ST_B_DN,
        ST_CHK,
        ST_EST,
        ST_Y_MUL,
        ST_Y_YS,
        ST_Y_CMP,
        ST_WALK,
        ST_FIN
    } t_state;

    t_state   r_state, n_state;
    t_out_sel r_out_sel, n_out_sel;
    logic     r_out_valid, n_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_sel   = r_out_sel;
        n_out_valid = r_out_valid && !i_m_ready;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_A_MUL;
                end
            end
            ST_A_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DIV100;
                o_cmd.ysrc    = YSRC_A;
                n_state       = ST_A_YS;
            end
            ST_A_YS: begin
                o_cmd.ys_en = 1'b1;
                o_cmd.ysrc  = YSRC_A;
                n_state     = ST_A_DN;
            end
            ST_A_DN: begin
                if (i_sts.a_bad) begin
                    n_out_sel = OUT_BAD;
                    n_state   = ST_FIN;
                end else begin
                    o_cmd.acc_op = ACC_DATE_A;
                    n_state      = i_sts.kind ? ST_B_MUL : ST_CHK;
                end
            end
            ST_B_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DIV100;
                o_cmd.ysrc    = YSRC_B;
                n_state       = ST_B_YS;
            end
            ST_B_YS: begin
                o_cmd.ys_en = 1'b1;
                o_cmd.ysrc  = YSRC_B;
                n_state     = ST_B_DN;
            end
            ST_B_DN: begin
                if (i_sts.b_bad) begin
                    n_out_sel = OUT_BAD;
                end else begin
                    o_cmd.acc_op = ACC_DIFF;
                    n_out_sel    = OUT_DIFF;
                end
                n_state = ST_FIN;
            end
            ST_CHK: begin
                if (i_sts.range_err) begin
                    n_out_sel = OUT_RANGE;
                    n_state   = ST_FIN;
                end else begin
                    o_cmd.mul_en  = 1'b1;
                    o_cmd.mul_sel = MUL_EST;
                    n_state       = ST_EST;
                end
            end
            ST_EST: begin
                o_cmd.yr_op = YR_EST;
                n_state     = ST_Y_MUL;
            end
            ST_Y_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_DIV100;
                o_cmd.ysrc    = YSRC_CAND;
                n_state       = ST_Y_YS;
            end
            ST_Y_YS: begin
                o_cmd.ys_en = 1'b1;
                o_cmd.ysrc  = YSRC_CAND;
                n_state     = ST_Y_CMP;
            end
            ST_Y_CMP: begin
                priority if (i_sts.ys_gt) begin
                    o_cmd.yr_op = YR_DEC;
                    n_state     = ST_Y_MUL;
                end else if (i_sts.rem_ge) begin
                    o_cmd.yr_op = YR_INC;
                    n_state     = ST_Y_MUL;
                end else begin
                    o_cmd.acc_op   = ACC_SUB_YS;
                    o_cmd.mon_init = 1'b1;
                    n_state        = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_sts.walk_done) begin
                    n_out_sel = OUT_DATE;
                    n_state   = ST_FIN;
                end else begin
                    o_cmd.acc_op = ACC_MONTH;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.out_load = 1'b1;
                    o_cmd.out_sel  = r_out_sel;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_out_sel   <= OUT_BAD;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_out_sel   <= n_out_sel;
        end
    end

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_m_valid = r_out_valid;

    a_fin_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && (!r_out_valid || i_m_ready)) |=>
            (r_out_valid && r_state == ST_IDLE))
        else $error("finished request not moved to output register");

    a_load_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_A_MUL))
        else $error("accepted request did not start");

    a_year_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_Y_CMP && !i_sts.ys_gt && !i_sts.rem_ge) |=> (r_state == ST_WALK))
        else $error("year search did not hand over to month walk");

endmodule

@@ rtl/gdod_datapath.sv @@
`timescale 1ns / 1ps

module gdod_datapath
    import gdod_pkg::*;
#(
    parameter int YEAR_MAX = YEAR_MAX_DEF
) (
    input  logic                     i_clk,
    input  t_dp_cmd                  i_cmd,
    input  logic                     i_kind,
    input  logic [YEAR_W-1:0]        i_year_a,
    input  logic [MONTH_W-1:0]       i_month_a,
    input  logic [DAY_W-1:0]         i_day_a,
    input  logic signed [OFF_W-1:0]  i_offset_days,
    input  logic [YEAR_W-1:0]        i_year_b,
    input  logic [MONTH_W-1:0]       i_month_b,
    input  logic [DAY_W-1:0]         i_day_b,
    output t_dp_sts                  o_sts,
    output logic [YEAR_W-1:0]        o_year_out,
    output logic [MONTH_W-1:0]       o_month_out,
    output logic [DAY_W-1:0]         o_day_out,
    output logic signed [DIFF_W-1:0] o_day_difference,
    output t_status                  o_status
);

    localparam int YE     = YEAR_MAX + 1;
    localparam int LAST_I = 365 * YE + (YE + 3) / 4 - (YE + 99) / 100 + (YE + 399) / 400 - 1;
    localparam int DMAX_I = 2 ** (DIFF_W - 1) - 1;
    localparam int DMIN_I = -(2 ** (DIFF_W - 1));

    localparam logic [YW-1:0]          YMAX   = YW'(YEAR_MAX);
    localparam logic signed [SN_W-1:0] LAST_S = SN_W'(LAST_I);
    localparam logic signed [SN_W-1:0] DMAX_S = SN_W'(DMAX_I);
    localparam logic signed [SN_W-1:0] DMIN_S = SN_W'(DMIN_I);

    logic                     r_kind;
    logic [YEAR_W-1:0]        r_ya, r_yb;
    logic [MONTH_W-1:0]       r_ma, r_mb;
    logic [DAY_W-1:0]         r_da, r_db;
    logic signed [OFF_W-1:0]  r_off;
    logic [PROD_W-1:0]        r_prod;
    logic [DN_W-1:0]          r_ys;
    logic                     r_leap;
    logic signed [SN_W-1:0]   r_acc;
    logic [YW-1:0]            r_yr;
    logic [MONTH_W-1:0]       r_mon;
    logic [YEAR_W-1:0]        r_year_out;
    logic [MONTH_W-1:0]       r_month_out;
    logic [DAY_W-1:0]         r_day_out;
    logic signed [DIFF_W-1:0] r_diff;
    t_status                  r_status;

    logic [YW-1:0]            y_sel;
    logic [DN_W-1:0]          mul_a;
    logic [MULB_W-1:0]        mul_b;
    logic [Q_W-1:0]           q100;
    logic [YW-1:0]            rem100;
    logic                     rem_zero;
    logic                     leap_c;
    logic [Q_W-1:0]           c100;
    logic [DN_W-1:0]          ys_c;
    logic signed [SN_W-1:0]   ys_s;
    logic signed [SN_W-1:0]   dn_a;
    logic signed [SN_W-1:0]   dn_b;
    logic signed [SN_W-1:0]   off_add;
    logic signed [SN_W-1:0]   year_len;
    logic [DAY_W-1:0]         dim;
    logic signed [SN_W-1:0]   dim_s;
    logic signed [DIFF_W-1:0] diff_sat;
    logic                     diff_ovf;

    always_comb begin
        unique case (i_cmd.ysrc)
            YSRC_A:    y_sel = YW'(r_ya);
            YSRC_B:    y_sel = YW'(r_yb);
            YSRC_CAND: y_sel = r_yr;
            default:   y_sel = '0;
        endcase
    end

    assign mul_a = (i_cmd.mul_sel == MUL_DIV100) ? DN_W'(y_sel) : r_acc[DN_W-1:0];
    assign mul_b = (i_cmd.mul_sel == MUL_DIV100) ? DIV100_K : EST_K;

    assign q100     = r_prod[DIV100_SH +: Q_W];
    assign rem100   = y_sel - YW'(q100) * YW'(100);
    assign rem_zero = (rem100 == '0);
    assign leap_c   = rem_zero ? (q100[1:0] == 2'b00) : (y_sel[1:0] == 2'b00);
    assign c100     = q100 + Q_W'(!rem_zero);
    assign ys_c     = DN_W'(y_sel) * DN_W'(365)
                    + DN_W'(({1'b0, y_sel} + (YW + 1)'(3)) >> 2)
                    - DN_W'(c100)
                    + DN_W'(({1'b0, c100} + (Q_W + 1)'(3)) >> 2);

    assign ys_s     = SN_W'(r_ys);
    assign dn_a     = ys_s + SN_W'(cum_days(r_ma, r_leap)) + SN_W'(r_da) - SN_W'(1);
    assign dn_b     = ys_s + SN_W'(cum_days(r_mb, r_leap)) + SN_W'(r_db) - SN_W'(1);
    assign off_add  = r_kind ? SN_W'(0) : SN_W'(r_off);
    assign year_len = r_leap ? SN_W'(366) : SN_W'(365);
    assign dim      = month_days(r_mon, r_leap);
    assign dim_s    = SN_W'(dim);

    always_comb begin
        diff_ovf = 1'b0;
        priority if (r_acc > DMAX_S) begin
            diff_sat = DMAX_S[DIFF_W-1:0];
            diff_ovf = 1'b1;
        end else if (r_acc < DMIN_S) begin
            diff_sat = DMIN_S[DIFF_W-1:0];
            diff_ovf = 1'b1;
        end else begin
            diff_sat = r_acc[DIFF_W-1:0];
        end
    end

    assign o_sts.kind      = r_kind;
    assign o_sts.a_bad     = (YW'(r_ya) > YMAX) || (r_ma == '0) || (r_ma > MONTH_W'(12))
                           || (r_da == '0) || (r_da > month_days(r_ma, r_leap));
    assign o_sts.b_bad     = (YW'(r_yb) > YMAX) || (r_mb == '0) || (r_mb > MONTH_W'(12))
                           || (r_db == '0) || (r_db > month_days(r_mb, r_leap));
    assign o_sts.range_err = (r_acc < SN_W'(0)) || (r_acc > LAST_S);
    assign o_sts.ys_gt     = (ys_s > r_acc);
    assign o_sts.rem_ge    = ((r_acc - ys_s) >= year_len);
    assign o_sts.walk_done = (r_mon == MONTH_W'(12)) || (r_acc < dim_s);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_ya   <= i_year_a;
            r_ma   <= i_month_a;
            r_da   <= i_day_a;
            r_off  <= i_offset_days;
            r_yb   <= i_year_b;
            r_mb   <= i_month_b;
            r_db   <= i_day_b;
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        if (i_cmd.ys_en) begin
            r_ys   <= ys_c;
            r_leap <= leap_c;
        end
        unique case (i_cmd.acc_op)
            ACC_HOLD:   r_acc <= r_acc;
            ACC_DATE_A: r_acc <= dn_a + off_add;
            ACC_DIFF:   r_acc <= r_acc - dn_b;
            ACC_SUB_YS: r_acc <= r_acc - ys_s;
            ACC_MONTH:  r_acc <= r_acc - dim_s;
            default:    r_acc <= r_acc;
        endcase
        unique case (i_cmd.yr_op)
            YR_HOLD: r_yr <= r_yr;
            YR_EST:  r_yr <= r_prod[EST_SH +: YW];
            YR_INC:  r_yr <= r_yr + YW'(1);
            YR_DEC:  r_yr <= r_yr - YW'(1);
            default: r_yr <= r_yr;
        endcase
        if (i_cmd.mon_init) begin
            r_mon <= MONTH_W'(1);
        end else if (i_cmd.acc_op == ACC_MONTH) begin
            r_mon <= r_mon + MONTH_W'(1);
        end
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_sel)
                OUT_DATE: begin
                    r_year_out  <= r_yr[YEAR_W-1:0];
                    r_month_out <= r_mon;
                    r_day_out   <= r_acc[DAY_W-1:0] + DAY_W'(1);
                    r_diff      <= '0;
                    r_status    <= STAT_OK;
                end
                OUT_DIFF: begin
                    r_year_out  <= '0;
                    r_month_out <= '0;
                    r_day_out   <= '0;
                    r_diff      <= diff_sat;
                    r_status    <= diff_ovf ? STAT_RANGE : STAT_OK;
                end
                OUT_BAD: begin
                    r_year_out  <= '0;
                    r_month_out <= '0;
                    r_day_out   <= '0;
                    r_diff      <= '0;
                    r_status    <= STAT_BAD_DATE;
                end
                OUT_RANGE: begin
                    r_year_out  <= '0;
                    r_month_out <= '0;
                    r_day_out   <= '0;
                    r_diff      <= '0;
                    r_status    <= STAT_RANGE;
                end
                default: begin
                    r_year_out  <= '0;
                    r_month_out <= '0;
                    r_day_out   <= '0;
                    r_diff      <= '0;
                    r_status    <= STAT_BAD_DATE;
                end
            endcase
        end
    end

    assign o_year_out       = r_year_out;
    assign o_month_out      = r_month_out;
    assign o_day_out        = r_day_out;
    assign o_day_difference = r_diff;
    assign o_status         = r_status;

endmodule

@@ rtl/gregorian_date_offset_and_difference.sv @@
`timescale 1ns / 1ps

// Gregorian date engine. A request either adds a signed day offset to date A
// (tuser 0) or returns the signed day count from date B to date A (tuser 1);
// each request yields exactly one result, with status 0 ok, 1 invalid input
// date, 2 year range left (dates zeroed) or difference saturated. One request
// is worked on at a time; a new one is taken while the previous result waits
// in the output register. An add that stays in the year range runs a year
// search (each candidate year goes through the shared multiplier that divides
// by 100, one or two candidates) and then a month walk (at most eleven months
// passed). A result still held in the output register holds the next one back
// in its last step until m_axis_tready takes it.
module gregorian_date_offset_and_difference
    import gdod_pkg::*;
#(
    parameter int YEAR_MAX = YEAR_MAX_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // year_a[13:0], month_a[17:14], day_a[22:18], offset_days[45:23],
    // year_b[59:46], month_b[63:60], day_b[68:64], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                   s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // year_out[13:0], month_out[17:14], day_out[22:18], day_difference[45:23], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // status
    output logic [STAT_W-1:0]      m_axis_tuser
);

    t_dp_cmd                  cmd;
    t_dp_sts                  sts;
    logic [YEAR_W-1:0]        year_out;
    logic [MONTH_W-1:0]       month_out;
    logic [DAY_W-1:0]         day_out;
    logic signed [DIFF_W-1:0] day_difference;
    t_status                  status;

    gdod_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_axis_tvalid),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .i_sts     (sts),
        .o_cmd     (cmd)
    );

    gdod_datapath #(
        .YEAR_MAX (YEAR_MAX)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_cmd            (cmd),
        .i_kind           (s_axis_tuser),
        .i_year_a         (s_axis_tdata[13:0]),
        .i_month_a        (s_axis_tdata[17:14]),
        .i_day_a          (s_axis_tdata[22:18]),
        .i_offset_days    (s_axis_tdata[45:23]),
        .i_year_b         (s_axis_tdata[59:46]),
        .i_month_b        (s_axis_tdata[63:60]),
        .i_day_b          (s_axis_tdata[68:64]),
        .o_sts            (sts),
        .o_year_out       (year_out),
        .o_month_out      (month_out),
        .o_day_out        (day_out),
        .o_day_difference (day_difference),
        .o_status         (status)
    );

    assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, day_difference, day_out, month_out, year_out};
    assign m_axis_tuser = status;

endmodule

@@ test/tb_calendar_pkg.sv @@
`timescale 1ns / 1ps

package tb_calendar_pkg;

    typedef enum logic {
        KIND_ADD  = 1'b0,
        KIND_DIFF = 1'b1
    } req_kind_t;

    function automatic bit leap_year(input int y);
        return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    endfunction

    function automatic int days_in_month(input int y, input int m);
        case (m)
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            2:                     return leap_year(y) ? 29 : 28;
            default:               return 0;
        endcase
    endfunction

endpackage

@@ test/calendar_checker.sv @@
`timescale 1ns / 1ps

module calendar_checker
    import gdod_pkg::*;
    import tb_calendar_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_req_valid,
    input  logic                   i_req_ready,
    input  logic [IN_TDATA_W-1:0]  i_req_data,
    input  logic                   i_req_kind,
    input  logic                   i_res_valid,
    input  logic                   i_res_ready,
    input  logic [OUT_TDATA_W-1:0] i_res_data,
    input  logic [STAT_W-1:0]      i_res_status,
    output int                     o_fail_count,
    output int                     o_pending,
    output int                     o_add_count,
    output int                     o_diff_count,
    output int                     o_invalid_count,
    output int                     o_range_count
);

    localparam int YEAR_LIMIT = YEAR_MAX_DEF;
    localparam int DIFF_HI    = 4194303;
    localparam int DIFF_LO    = -4194304;

    typedef struct packed {
        req_kind_t             kind;
        logic [YEAR_W-1:0]     year_a;
        logic [MONTH_W-1:0]    month_a;
        logic [DAY_W-1:0]      day_a;
        logic signed [OFF_W-1:0] offset;
        logic [YEAR_W-1:0]     year_b;
        logic [MONTH_W-1:0]    month_b;
        logic [DAY_W-1:0]      day_b;
    } calendar_request_t;

    typedef struct packed {
        logic [YEAR_W-1:0]        year;
        logic [MONTH_W-1:0]       month;
        logic [DAY_W-1:0]         day;
        logic signed [DIFF_W-1:0] diff;
        t_status                  status;
    } calendar_result_t;

    calendar_result_t         expected_dates[$];
    calendar_request_t        req;
    calendar_result_t         want;
    logic [IN_PAD_W-1:0]      req_pad;
    logic [OUT_PAD_W-1:0]     res_pad;
    logic [YEAR_W-1:0]        got_year;
    logic [MONTH_W-1:0]       got_month;
    logic [DAY_W-1:0]         got_day;
    logic signed [DIFF_W-1:0] got_diff;
    int                       fail_total   = 0;
    int                       adds_seen    = 0;
    int                       diffs_seen   = 0;
    int                       invalid_seen = 0;
    int                       range_seen   = 0;

    assign o_fail_count    = fail_total;
    assign o_add_count     = adds_seen;
    assign o_diff_count    = diffs_seen;
    assign o_invalid_count = invalid_seen;
    assign o_range_count   = range_seen;

    function automatic int jan1_index(input int y);
        return 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    function automatic bit date_valid(input int y, input int m, input int d);
        return (y <= YEAR_LIMIT) && (m >= 1) && (m <= 12) && (d >= 1) &&
               (d <= days_in_month(y, m));
    endfunction

    function automatic int day_index(input int y, input int m, input int d);
        int n;
        int k;
        n = jan1_index(y);
        for (k = 1; k < m; k++) begin
            n += days_in_month(y, k);
        end
        return n + d - 1;
    endfunction

    function automatic calendar_result_t predict_date(input calendar_request_t r);
        calendar_result_t res;
        int               n;
        int               last;
        int               y;
        int               m;
        int               diff;
        res = '0;
        if (!date_valid(r.year_a, r.month_a, r.day_a) ||
            (r.kind == KIND_DIFF && !date_valid(r.year_b, r.month_b, r.day_b))) begin
            res.status = STAT_BAD_DATE;
        end else if (r.kind == KIND_ADD) begin
            n    = day_index(r.year_a, r.month_a, r.day_a) + int'($signed(r.offset));
            last = day_index(YEAR_LIMIT, 12, 31);
            if (n < 0 || n > last) begin
                res.status = STAT_RANGE;
            end else begin
                y = (n * 400) / 146097;
                while (y > 0 && jan1_index(y) > n) y--;
                while (jan1_index(y + 1) <= n) y++;
                n -= jan1_index(y);
                m = 1;
                while (m < 12 && n >= days_in_month(y, m)) begin
                    n -= days_in_month(y, m);
                    m++;
                end
                res.year  = YEAR_W'(y);
                res.month = MONTH_W'(m);
                res.day   = DAY_W'(n + 1);
            end
        end else begin
            diff = day_index(r.year_a, r.month_a, r.day_a) -
                   day_index(r.year_b, r.month_b, r.day_b);
            if (diff > DIFF_HI) begin
                diff       = DIFF_HI;
                res.status = STAT_RANGE;
            end else if (diff < DIFF_LO) begin
                diff       = DIFF_LO;
                res.status = STAT_RANGE;
            end
            res.diff = DIFF_W'(diff);
        end
        return res;
    endfunction

    task automatic check_field(input string what, input int exp_val, input int act_val);
        if (exp_val != act_val) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_val, act_val);
            fail_total++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // retire the oldest date first, then queue the new request
            if (i_res_valid && i_res_ready) begin
                {res_pad, got_diff, got_day, got_month, got_year} = i_res_data;
                if (expected_dates.size() == 0) begin
                    $display("%0t ns: result with none outstanding, expected nothing, actual %h/%0d",
                             $time, i_res_data, i_res_status);
                    fail_total++;
                end else begin
                    want = expected_dates.pop_front();
                    check_field("year_out", want.year, got_year);
                    check_field("month_out", want.month, got_month);
                    check_field("day_out", want.day, got_day);
                    check_field("day_difference", int'(want.diff), int'(got_diff));
                    check_field("status", int'(want.status), int'(i_res_status));
                    if (want.status == STAT_BAD_DATE) invalid_seen++;
                    if (want.status == STAT_RANGE) range_seen++;
                end
            end
            if (i_req_valid && i_req_ready) begin
                {req_pad, req.day_b, req.month_b, req.year_b, req.offset,
                 req.day_a, req.month_a, req.year_a} = i_req_data;
                req.kind = req_kind_t'(i_req_kind);
                expected_dates.push_back(predict_date(req));
                if (req.kind == KIND_ADD) adds_seen++;
                else diffs_seen++;
            end
        end
        o_pending <= expected_dates.size();
    end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;

    import gdod_pkg::*;
    import tb_calendar_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 500;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;   // year_a, month_a, day_a, offset_days, year_b,
                                            // month_b, day_b, zero pad
    logic                   s_axis_tuser;   // kind
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;   // year_out, month_out, day_out, day_difference,
                                            // zero pad
    logic [STAT_W-1:0]      m_axis_tuser;   // status

    int fail_count;
    int pending;
    int add_count;
    int diff_count;
    int invalid_count;
    int range_count;
    int cycle_count    = 0;
    int rx_stall_left  = 0;
    bit calm           = 1'b0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    gregorian_date_offset_and_difference i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    calendar_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (s_axis_tvalid),
        .i_req_ready     (s_axis_tready),
        .i_req_data      (s_axis_tdata),
        .i_req_kind      (s_axis_tuser),
        .i_res_valid     (m_axis_tvalid),
        .i_res_ready     (m_axis_tready),
        .i_res_data      (m_axis_tdata),
        .i_res_status    (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_add_count     (add_count),
        .o_diff_count    (diff_count),
        .o_invalid_count (invalid_count),
        .o_range_count   (range_count)
    );

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL gregorian_date_offset_and_difference");
            $finish;
        end
    end

    // stall the result side in random bursts
    always @(posedge i_clk) begin
        if (rx_stall_left != 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            rx_stall_left <= $urandom_range(0, 7);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_request(input req_kind_t kind, input int ya, input int ma,
                                input int da, input int off, input int yb, input int mb,
                                input int db);
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {IN_PAD_W'(0), DAY_W'(db), MONTH_W'(mb), YEAR_W'(yb), OFF_W'(off),
                          DAY_W'(da), MONTH_W'(ma), YEAR_W'(ya)};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    endtask

    task automatic send_add(input int y, input int m, input int d, input int off);
        send_request(KIND_ADD, y, m, d, off, $urandom(), $urandom(), $urandom());
    endtask

    task automatic send_diff(input int ya, input int ma, input int da,
                             input int yb, input int mb, input int db);
        send_request(KIND_DIFF, ya, ma, da, $urandom(), yb, mb, db);
    endtask

    task automatic wait_drained();
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic random_date(output int y, output int m, output int d);
        int pick;
        pick = $urandom_range(0, 19);
        if (pick == 0) y = $urandom_range(0, 3);
        else if (pick == 1) y = $urandom_range(9996, 9999);
        else if (pick == 2) y = $urandom_range(10000, 16383);
        else if (pick < 6) y = 400 * $urandom_range(0, 24) + 100 * $urandom_range(0, 3);
        else y = $urandom_range(0, 9999);
        m = ($urandom_range(0, 15) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 12);
        if ($urandom_range(0, 15) == 0) d = $urandom_range(0, 31);
        else if ($urandom_range(0, 3) == 0) d = days_in_month(y, m);
        else d = $urandom_range(1, days_in_month(y, m));
    endtask

    function automatic int random_offset();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) return $urandom_range(0, 800) - 400;
        if (pick < 8) return $urandom_range(0, 262143) - 131072;
        return $urandom_range(0, 8388607) - 4194304;
    endfunction

    initial begin
        int ya;
        int ma;
        int da;
        int yb;
        int mb;
        int db;
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // range ends, leap rules, malformed dates, extreme offsets
        send_add(0, 1, 1, 0);
        send_add(0, 1, 1, -1);
        send_add(9999, 12, 31, 0);
        send_add(9999, 12, 31, 1);
        send_add(0, 1, 1, 3652424);
        send_add(0, 1, 1, 4194303);
        send_add(9999, 12, 31, -4194304);
        send_add(2000, 2, 28, 1);
        send_add(1900, 2, 28, 1);
        send_add(2000, 2, 29, 366);
        send_add(2024, 12, 31, -366);
        send_add(1900, 2, 29, 5);
        send_add(2023, 0, 10, 5);
        send_add(2023, 13, 1, 5);
        send_add(16383, 15, 31, 5);
        send_add(2023, 4, 31, 5);
        send_add(2023, 1, 0, 5);
        send_add(10000, 1, 1, 0);
        send_diff(9999, 12, 31, 0, 1, 1);
        send_diff(0, 1, 1, 9999, 12, 31);
        send_diff(2024, 2, 29, 2024, 2, 29);
        send_diff(2000, 3, 1, 1900, 3, 1);
        send_diff(2023, 6, 15, 16383, 15, 31);
        send_diff(2023, 6, 0, 2023, 6, 15);
        send_diff(2023, 6, 15, 2023, 0, 15);
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
            if (i >= RANDOM_ITEMS - 80) calm = 1'b1;
            if (i == RANDOM_ITEMS / 2) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            random_date(ya, ma, da);
            random_date(yb, mb, db);
            if ($urandom_range(0, 1) == 1) send_diff(ya, ma, da, yb, mb, db);
            else send_add(ya, ma, da, random_offset());
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (40) @(posedge i_clk);

        $display("Covered %0d date additions and %0d date differences under random stalls.",
                 add_count, diff_count);
        $display("Of these, %0d had a malformed date and %0d left the year range.",
                 invalid_count, range_count);
        if (fail_count == 0) begin
            $display("PASS gregorian_date_offset_and_difference");
        end else begin
            $display("FAIL gregorian_date_offset_and_difference");
        end
        $finish;
    end

endmodule
